// ----- rtl/joystick_differential_drive_mixer_defines.svh -----
// Assertion helpers shared by the mixer RTL.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JDDM_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JDDM_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/jddm_pkg.sv -----
package jddm_pkg;

	localparam int unsigned FRACTION_BITS_DEF = 15;
	localparam int unsigned RAW_FULL = 32767;
	localparam int unsigned PWM_MAX = 255;
	localparam int unsigned DEAD_BAND_MAX = 16384;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 15;

	localparam logic [14:0] DEAD_BAND_RST = 15'd4915;
	localparam logic [14:0] TURN_GAIN_RST = 15'd22938;
	localparam logic [7:0] STEER_ID_RST = 8'd0;
	localparam logic [7:0] LEFT_TRIG_ID_RST = 8'd2;
	localparam logic [7:0] RIGHT_TRIG_ID_RST = 8'd5;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEAD_BAND = 3'd0,
		REG_TURN_GAIN = 3'd1,
		REG_STEER_ID = 3'd2,
		REG_LEFT_TRIG_ID = 3'd3,
		REG_RIGHT_TRIG_ID = 3'd4
	} cfg_reg_t;

	// Operand width of the shared multiply-divide unit for a given fraction width.
	function automatic int unsigned op_width(input int unsigned fbits);
		return (fbits > 15) ? fbits : 15;
	endfunction

endpackage

// ----- rtl/jddm_muldiv.sv -----
module jddm_muldiv #(
	parameter int unsigned WIDTH = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] c,
	output logic             done,
	output logic [WIDTH-1:0] q
);
	`include "joystick_differential_drive_mixer_defines.svh"

	// Computes a * b / c, truncated, with one multiplier bit and then one
	// quotient bit per cycle. The quotient must fit in WIDTH bits.

	localparam int unsigned CW = $clog2(WIDTH);

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

	md_state_t          phase_q;
	logic [2*WIDTH-1:0] acc_q;
	logic [WIDTH-1:0]   a_q;
	logic [WIDTH-1:0]   c_q;
	logic [CW-1:0]      cnt_q;
	logic               done_q;

	logic [WIDTH:0]     mul_sum;
	logic [WIDTH:0]     div_trial;
	logic [WIDTH:0]     div_diff;
	logic               div_ge;
	logic [WIDTH-1:0]   div_hi;

	always_comb begin
		mul_sum = {1'b0, acc_q[2*WIDTH-1:WIDTH]} + (acc_q[0] ? {1'b0, a_q} : '0);
		div_trial = {acc_q[2*WIDTH-1:WIDTH], acc_q[WIDTH-1]};
		div_diff = div_trial - {1'b0, c_q};
		div_ge = div_trial >= {1'b0, c_q};
		div_hi = div_ge ? div_diff[WIDTH-1:0] : div_trial[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MD_IDLE;
			acc_q <= '0;
			a_q <= '0;
			c_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (phase_q == MD_DIV) && (cnt_q == CW'(WIDTH - 1));
			unique case (phase_q)
				MD_IDLE: begin
					if (start) begin
						acc_q <= {{WIDTH{1'b0}}, b};
						a_q <= a;
						c_q <= c;
						cnt_q <= '0;
						phase_q <= MD_MUL;
					end
				end
				MD_MUL: begin
					acc_q <= {mul_sum, acc_q[WIDTH-1:1]};
					if (cnt_q == CW'(WIDTH - 1)) begin
						cnt_q <= '0;
						phase_q <= MD_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				MD_DIV: begin
					acc_q <= {div_hi, acc_q[WIDTH-2:0], div_ge};
					if (cnt_q == CW'(WIDTH - 1)) begin
						cnt_q <= '0;
						phase_q <= MD_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: phase_q <= MD_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign q = acc_q[WIDTH-1:0];

	`JDDM_ASSERT_NOW(a_md_start_idle, clk, arst_n, start, phase_q == MD_IDLE,
		"multiply-divide started while busy")
	`JDDM_ASSERT_NOW(a_md_done_after_div, clk, arst_n, done_q, $past(phase_q == MD_DIV),
		"done raised without a division pass")
	`JDDM_ASSERT_NOW(a_md_remainder, clk, arst_n, done_q, acc_q[2*WIDTH-1:WIDTH] < c_q,
		"final remainder not below the divisor")

endmodule

// ----- rtl/joystick_differential_drive_mixer.sv -----
// Arcade drive mixer: each input word is an axis event or a stop request and
// yields one output word with two 8-bit PWM duties and H-bridge pin pairs.
// All multiplications and divisions run on one shared multiply-divide unit
// that handles one bit per cycle; its operand width W is the larger of
// FRACTION_BITS and 15. An axis event uses up to eight unit operations (raw
// rescale, dead band rescale, dead band division, gain rescale, steering
// product, inner wheel slowdown, two duties), and fewer when the axis is
// unknown, the level falls in the dead band or the steering is centered. A
// finished word waits in the output register while the next input word is
// already being taken. Configuration writes are accepted in every cycle.
module joystick_differential_drive_mixer #(
	parameter int unsigned FRACTION_BITS = jddm_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [jddm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [jddm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [7:0]                          axis_id,
	input  logic signed [15:0]                  axis_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          left_duty,
	output logic                                left_pin_a,
	output logic                                left_pin_b,
	output logic [7:0]                          right_duty,
	output logic                                right_pin_a,
	output logic                                right_pin_b
);
	import jddm_pkg::*;
	`include "joystick_differential_drive_mixer_defines.svh"

	localparam int unsigned F = FRACTION_BITS;
	localparam int unsigned OW = op_width(FRACTION_BITS);
	localparam logic [OW-1:0] FULL_W = OW'((64'd1 << F) - 64'd1);
	localparam logic [OW-1:0] RAW_FULL_W = OW'(RAW_FULL);
	localparam logic [OW-1:0] PWM_MAX_W = OW'(PWM_MAX);
	localparam logic [14:0] DEAD_BAND_MAX_W = 15'(DEAD_BAND_MAX);

	typedef enum logic [3:0] {
		S_IDLE,
		S_XSCALE,
		S_DSCALE,
		S_DZONE,
		S_MIX,
		S_GSCALE,
		S_PROD,
		S_SLOW,
		S_LDUTY,
		S_RDUTY,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		TGT_STEER,
		TGT_FWD,
		TGT_REV,
		TGT_NONE
	} target_t;

	logic [14:0] dead_band_q;
	logic [14:0] turn_gain_q;
	logic [7:0]  steer_id_q;
	logic [7:0]  left_trig_id_q;
	logic [7:0]  right_trig_id_q;

	state_t      state_q;
	logic        wait_q;
	target_t     tgt_q;
	logic        stop_q;
	logic        val_neg_q;
	logic [14:0] raw_mag_q;
	logic [OW-1:0] m_q;
	logic        m_neg_q;
	logic [OW-1:0] d_q;
	logic [OW-1:0] g_q;
	logic [OW-1:0] factor_q;
	logic [F-1:0] steer_mag_q;
	logic        steer_neg_q;
	logic [F-1:0] fwd_mag_q;
	logic [F-1:0] rev_mag_q;
	logic [F-1:0] lmag_q;
	logic [F-1:0] rmag_q;
	logic        l_neg_q;
	logic        r_neg_q;
	logic [7:0]  ldut_q;
	logic [7:0]  rdut_q;

	logic        out_valid_q;
	logic [7:0]  left_duty_q;
	logic        left_pin_a_q;
	logic        left_pin_b_q;
	logic [7:0]  right_duty_q;
	logic        right_pin_a_q;
	logic        right_pin_b_q;

	logic          md_start;
	logic          md_done;
	logic [OW-1:0] md_a;
	logic [OW-1:0] md_b;
	logic [OW-1:0] md_c;
	logic [OW-1:0] md_q;

	logic [15:0]   abs_raw;
	logic [14:0]   raw_mag;
	logic [OW:0]   trig_sum;
	logic [OW-1:0] trig_diff;
	logic [OW-1:0] trig_m;
	logic          m_lt_d;
	logic [OW-1:0] dz_r;
	logic          thr_neg;
	logic [F-1:0]  thr_mag;
	logic          unit_op;
	logic          out_free;
	target_t       tgt_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_band_q <= DEAD_BAND_RST;
			turn_gain_q <= TURN_GAIN_RST;
			steer_id_q <= STEER_ID_RST;
			left_trig_id_q <= LEFT_TRIG_ID_RST;
			right_trig_id_q <= RIGHT_TRIG_ID_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEAD_BAND: begin
					dead_band_q <= (cfg_data > DEAD_BAND_MAX_W) ? DEAD_BAND_MAX_W : cfg_data;
				end
				REG_TURN_GAIN: turn_gain_q <= cfg_data;
				REG_STEER_ID: steer_id_q <= cfg_data[7:0];
				REG_LEFT_TRIG_ID: left_trig_id_q <= cfg_data[7:0];
				REG_RIGHT_TRIG_ID: right_trig_id_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		abs_raw = axis_value[15] ? 16'(-axis_value) : axis_value;
		raw_mag = abs_raw[15] ? 15'h7FFF : abs_raw[14:0];
		if (axis_id == steer_id_q) begin
			tgt_new = TGT_STEER;
		end else if (axis_id == right_trig_id_q) begin
			tgt_new = TGT_FWD;
		end else if (axis_id == left_trig_id_q) begin
			tgt_new = TGT_REV;
		end else begin
			tgt_new = TGT_NONE;
		end
		trig_sum = {1'b0, FULL_W} + {1'b0, md_q};
		trig_diff = FULL_W - md_q;
		trig_m = val_neg_q ? {1'b0, trig_diff[OW-1:1]} : trig_sum[OW:1];
		m_lt_d = m_q < d_q;
		dz_r = (md_q > FULL_W) ? FULL_W : md_q;
		thr_neg = rev_mag_q > fwd_mag_q;
		thr_mag = thr_neg ? (rev_mag_q - fwd_mag_q) : (fwd_mag_q - rev_mag_q);
		out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		md_a = '0;
		md_b = FULL_W;
		md_c = FULL_W;
		unit_op = 1'b1;
		unique case (state_q)
			S_XSCALE: begin
				md_a = OW'(raw_mag_q);
				md_c = RAW_FULL_W;
			end
			S_DSCALE: begin
				md_a = OW'(dead_band_q);
				md_c = RAW_FULL_W;
			end
			S_DZONE: begin
				md_a = m_q - d_q;
				md_c = FULL_W - d_q;
				unit_op = !m_lt_d;
			end
			S_GSCALE: begin
				md_a = OW'(turn_gain_q);
				md_c = RAW_FULL_W;
			end
			S_PROD: begin
				md_a = OW'(steer_mag_q);
				md_b = g_q;
			end
			S_SLOW: begin
				md_a = OW'(lmag_q);
				md_b = factor_q;
			end
			S_LDUTY: begin
				md_a = OW'(lmag_q);
				md_b = PWM_MAX_W;
			end
			S_RDUTY: begin
				md_a = OW'(rmag_q);
				md_b = PWM_MAX_W;
			end
			default: unit_op = 1'b0;
		endcase
		md_start = unit_op && !wait_q;
	end

	jddm_muldiv #(
		.WIDTH(OW)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.a      (md_a),
		.b      (md_b),
		.c      (md_c),
		.done   (md_done),
		.q      (md_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q <= 1'b0;
			tgt_q <= TGT_NONE;
			stop_q <= 1'b0;
			val_neg_q <= 1'b0;
			raw_mag_q <= '0;
			m_q <= '0;
			m_neg_q <= 1'b0;
			d_q <= '0;
			g_q <= '0;
			factor_q <= '0;
			steer_mag_q <= '0;
			steer_neg_q <= 1'b0;
			fwd_mag_q <= '0;
			rev_mag_q <= '0;
			lmag_q <= '0;
			rmag_q <= '0;
			l_neg_q <= 1'b0;
			r_neg_q <= 1'b0;
			ldut_q <= '0;
			rdut_q <= '0;
			out_valid_q <= 1'b0;
			left_duty_q <= '0;
			left_pin_a_q <= 1'b0;
			left_pin_b_q <= 1'b0;
			right_duty_q <= '0;
			right_pin_a_q <= 1'b0;
			right_pin_b_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (md_start) begin
				wait_q <= 1'b1;
			end else if (md_done) begin
				wait_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						stop_q <= opcode;
						val_neg_q <= axis_value[15];
						raw_mag_q <= raw_mag;
						tgt_q <= tgt_new;
						if (opcode) begin
							state_q <= S_OUT;
						end else if (tgt_new == TGT_NONE) begin
							state_q <= S_MIX;
						end else begin
							state_q <= S_XSCALE;
						end
					end
				end
				S_XSCALE: begin
					if (md_done) begin
						if (tgt_q == TGT_STEER) begin
							m_q <= md_q;
							m_neg_q <= val_neg_q;
						end else begin
							m_q <= trig_m;
							m_neg_q <= 1'b0;
						end
						state_q <= S_DSCALE;
					end
				end
				S_DSCALE: begin
					if (md_done) begin
						d_q <= md_q;
						state_q <= S_DZONE;
					end
				end
				S_DZONE: begin
					if (!wait_q && m_lt_d) begin
						unique case (tgt_q)
							TGT_STEER: begin
								steer_mag_q <= '0;
								steer_neg_q <= 1'b0;
							end
							TGT_FWD: fwd_mag_q <= '0;
							TGT_REV: rev_mag_q <= '0;
							default: ;
						endcase
						state_q <= S_MIX;
					end else if (md_done) begin
						unique case (tgt_q)
							TGT_STEER: begin
								steer_mag_q <= dz_r[F-1:0];
								steer_neg_q <= m_neg_q;
							end
							TGT_FWD: fwd_mag_q <= dz_r[F-1:0];
							TGT_REV: rev_mag_q <= dz_r[F-1:0];
							default: ;
						endcase
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					lmag_q <= thr_mag;
					rmag_q <= thr_mag;
					l_neg_q <= thr_neg;
					r_neg_q <= thr_neg;
					state_q <= (steer_mag_q == '0) ? S_LDUTY : S_GSCALE;
				end
				S_GSCALE: begin
					if (md_done) begin
						g_q <= md_q;
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					if (md_done) begin
						factor_q <= FULL_W - md_q;
						state_q <= S_SLOW;
					end
				end
				S_SLOW: begin
					if (md_done) begin
						if (steer_neg_q) begin
							lmag_q <= md_q[F-1:0];
							l_neg_q <= l_neg_q && (md_q != '0);
						end else begin
							rmag_q <= md_q[F-1:0];
							r_neg_q <= r_neg_q && (md_q != '0);
						end
						state_q <= S_LDUTY;
					end
				end
				S_LDUTY: begin
					if (md_done) begin
						ldut_q <= md_q[7:0];
						state_q <= S_RDUTY;
					end
				end
				S_RDUTY: begin
					if (md_done) begin
						rdut_q <= md_q[7:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						left_duty_q <= stop_q ? 8'd0 : ldut_q;
						left_pin_a_q <= !stop_q && !l_neg_q;
						left_pin_b_q <= !stop_q && l_neg_q;
						right_duty_q <= stop_q ? 8'd0 : rdut_q;
						right_pin_a_q <= !stop_q && !r_neg_q;
						right_pin_b_q <= !stop_q && r_neg_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign left_duty = left_duty_q;
	assign left_pin_a = left_pin_a_q;
	assign left_pin_b = left_pin_b_q;
	assign right_duty = right_duty_q;
	assign right_pin_a = right_pin_a_q;
	assign right_pin_b = right_pin_b_q;

	`JDDM_ASSERT_NEXT(a_out_load, clk, arst_n, state_q == S_OUT && out_free,
		out_valid && state_q == S_IDLE, "finished word not loaded into output register")
	`JDDM_ASSERT_NOW(a_pins_exclusive, clk, arst_n, out_valid,
		!(left_pin_a && left_pin_b) && !(right_pin_a && right_pin_b),
		"bridge pins driven high together")
	`JDDM_ASSERT_NOW(a_dead_band_sat, clk, arst_n, 1'b1, dead_band_q <= DEAD_BAND_MAX_W,
		"dead band register above its limit")

endmodule
